@@ design/necir_pkg.sv @@
// ----------------------------------------------------------------------------
// necir_pkg
// Shared types, constants and helper functions for the NEC IR frame decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

  localparam int unsigned TS_W  = 32;
  localparam int unsigned DIV_W = 10;
  localparam int unsigned CNT_W = $clog2(TS_W);

  localparam logic [DIV_W-1:0] CYCLES_PER_US_RST = 10'd72;

  // Request types carried on req_type.
  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  // Interval windows in microseconds, inclusive at both ends.
  localparam logic [TS_W-1:0] LEADER_LO = 32'd12500;
  localparam logic [TS_W-1:0] LEADER_HI = 32'd14500;
  localparam logic [TS_W-1:0] REPEAT_LO = 32'd10200;
  localparam logic [TS_W-1:0] REPEAT_HI = 32'd12100;
  localparam logic [TS_W-1:0] ZERO_LO   = 32'd800;
  localparam logic [TS_W-1:0] ZERO_HI   = 32'd1500;
  localparam logic [TS_W-1:0] ONE_LO    = 32'd1750;
  localparam logic [TS_W-1:0] ONE_HI    = 32'd2800;

  localparam logic [7:0] INV_MASK = 8'hFF;

  // Edge classes reported on edge_class.
  localparam logic [2:0] CLS_LEADER  = 3'd0;
  localparam logic [2:0] CLS_REPEAT  = 3'd1;
  localparam logic [2:0] CLS_ZERO    = 3'd2;
  localparam logic [2:0] CLS_ONE     = 3'd3;
  localparam logic [2:0] CLS_INVALID = 3'd4;
  localparam logic [2:0] CLS_NONE    = 3'd5;

  // Command bytes with a key assigned.
  localparam logic [7:0] CMD_KEY1  = 8'h10;
  localparam logic [7:0] CMD_KEY2  = 8'h11;
  localparam logic [7:0] CMD_KEY3  = 8'h12;
  localparam logic [7:0] CMD_KEY4  = 8'h14;
  localparam logic [7:0] CMD_STOP  = 8'h0D;
  localparam logic [7:0] CMD_AUDIO = 8'h05;

  localparam logic [2:0] KEY_NONE  = 3'd0;
  localparam logic [2:0] KEY_1     = 3'd1;
  localparam logic [2:0] KEY_2     = 3'd2;
  localparam logic [2:0] KEY_3     = 3'd3;
  localparam logic [2:0] KEY_4     = 3'd4;
  localparam logic [2:0] KEY_STOP  = 3'd5;
  localparam logic [2:0] KEY_AUDIO = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  function automatic logic in_window(input logic [TS_W-1:0] v,
                                     input logic [TS_W-1:0] lo,
                                     input logic [TS_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic [2:0] map_key(input logic [7:0] cmd);
    logic [2:0] key;
    case (cmd)
      CMD_KEY1:  key = KEY_1;
      CMD_KEY2:  key = KEY_2;
      CMD_KEY3:  key = KEY_3;
      CMD_KEY4:  key = KEY_4;
      CMD_STOP:  key = KEY_STOP;
      CMD_AUDIO: key = KEY_AUDIO;
      default:   key = KEY_NONE;
    endcase
    return key;
  endfunction

endpackage

@@ design/necir_div.sv @@
// ----------------------------------------------------------------------------
// necir_div
// Restoring serial divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module necir_div
  import necir_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TS_W-1:0]   dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              busy,
  output logic              done,
  output logic [TS_W-1:0]   quotient
);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [TS_W-1:0]  quo;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial    = {rem, quo[TS_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(TS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      // A divisor of zero behaves as one.
      dvs <= (divisor == '0) ? DIV_W'(1) : divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DIV_W-1:0];
      end
      quo <= {quo[TS_W-2:0], fits};
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < dvs))
    else $error("divider remainder reached the divisor");

  a_last_step_done: assert property (@(posedge clk) disable iff (rst)
    busy && !start && (cnt == CNT_W'(TS_W - 1)) |=> done && !busy)
    else $error("divider did not finish after the last step");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider signalled done while still busy");

endmodule

@@ design/nec_ir_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// NEC infrared frame decoder driven by falling-edge timestamps.
//
// An edge item turns the cycles since the previous edge into microseconds with
// a serial divider that produces one quotient bit per clock; an edge item
// passes through the load, 32 divide steps, the classify-and-write step and
// the output register, while a take item goes straight to classify-and-write.
// The divider is the only long path and is reused by every edge item, and the
// block accepts one item at a time. The result waits in an output register,
// so a stalled consumer holds back only the next item's completion.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder
  import necir_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [DIV_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  logic [TS_W-1:0]   timestamp,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        edge_class,
  output logic              frame_done,
  output logic [7:0]        last_cmd,
  output logic [2:0]        virtual_key
);

  state_t state, state_next;

  logic [DIV_W-1:0] cycles_per_us;
  logic [TS_W-1:0]  prev_edge_time;
  logic [TS_W-1:0]  frame_bits, frame_bits_next;
  logic [4:0]       bit_count, bit_count_next;
  logic             receiving, receiving_next;
  logic [7:0]       pending_cmd, pending_cmd_next;
  logic             pending_valid, pending_valid_next;
  logic [7:0]       last_command, last_command_next;
  logic             req_take;

  logic             in_accept;
  logic             out_free;
  logic             finish;
  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [TS_W-1:0]  us;
  logic [TS_W-1:0]  bits_or;
  logic             is_zero, is_one;
  logic [2:0]       cls_next;
  logic             done_next;
  logic [2:0]       key_next;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign div_start = in_accept && (req_type == REQ_EDGE);
  assign out_free  = !out_valid || !out_stall;
  assign finish    = (state == ST_FINISH) && out_free;

  necir_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (timestamp - prev_edge_time),
    .divisor  (cycles_per_us),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (us)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (req_type == REQ_TAKE) ? ST_FINISH : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Classification, frame assembly and take handling, applied when the result is written.
  always_comb begin
    frame_bits_next    = frame_bits;
    bit_count_next     = bit_count;
    receiving_next     = receiving;
    pending_cmd_next   = pending_cmd;
    pending_valid_next = pending_valid;
    last_command_next  = last_command;
    cls_next           = CLS_NONE;
    done_next          = 1'b0;
    key_next           = KEY_NONE;
    is_zero            = in_window(us, ZERO_LO, ZERO_HI);
    is_one             = in_window(us, ONE_LO, ONE_HI);
    bits_or            = frame_bits | (TS_W'(is_one) << bit_count);

    if (req_take) begin
      if (pending_valid) begin
        key_next           = map_key(pending_cmd);
        pending_valid_next = 1'b0;
      end
    end else if (in_window(us, LEADER_LO, LEADER_HI)) begin
      cls_next        = CLS_LEADER;
      frame_bits_next = '0;
      bit_count_next  = '0;
      receiving_next  = 1'b1;
    end else if (in_window(us, REPEAT_LO, REPEAT_HI)) begin
      cls_next       = CLS_REPEAT;
      receiving_next = 1'b0;
    end else if (receiving) begin
      if (!is_zero && !is_one) begin
        cls_next       = CLS_INVALID;
        receiving_next = 1'b0;
        bit_count_next = '0;
      end else begin
        cls_next        = is_one ? CLS_ONE : CLS_ZERO;
        frame_bits_next = bits_or;
        if (bit_count == 5'd31) begin
          receiving_next = 1'b0;
          bit_count_next = '0;
          if (((bits_or[7:0] ^ bits_or[15:8]) == INV_MASK) &&
              ((bits_or[23:16] ^ bits_or[31:24]) == INV_MASK)) begin
            last_command_next  = bits_or[23:16];
            pending_cmd_next   = bits_or[23:16];
            pending_valid_next = 1'b1;
            done_next          = 1'b1;
          end
        end else begin
          bit_count_next = bit_count + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_us  <= CYCLES_PER_US_RST;
      prev_edge_time <= '0;
      frame_bits     <= '0;
      bit_count      <= '0;
      receiving      <= 1'b0;
      pending_cmd    <= '0;
      pending_valid  <= 1'b0;
      last_command   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cycles_per_us <= cfg_wr_data;
      end
      if (div_start) begin
        prev_edge_time <= timestamp;
      end
      if (finish) begin
        frame_bits    <= frame_bits_next;
        bit_count     <= bit_count_next;
        receiving     <= receiving_next;
        pending_cmd   <= pending_cmd_next;
        pending_valid <= pending_valid_next;
        last_command  <= last_command_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_take <= (req_type == REQ_TAKE);
    end
    if (finish) begin
      edge_class  <= cls_next;
      frame_done  <= done_next;
      last_cmd    <= last_command_next;
      virtual_key <= key_next;
    end
  end

  a_div_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVIDE))
    else $error("divider finished outside the divide state");

  a_divide_keeps_divider_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (div_busy || div_done))
    else $error("sequencer waits on an idle divider");

  a_pending_cleared_by_take: assert property (@(posedge clk) disable iff (rst)
    $fell(pending_valid) |-> $past(finish && req_take))
    else $error("pending command dropped without a take item");

endmodule
